[design/ray_triangle_intersect_macros.svh]
// Assertion macros for the ray/triangle intersection RTL.
// Included by the file that carries the concurrent assertions; no other dependencies.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray_triangle_intersect assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray_triangle_intersect assertion failed");

`endif

[design/rti_pkg.sv]
// Shared constants, register codes and stage control type for the
// ray/triangle intersection pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

  parameter int COORD_WIDTH_DEF = 16;
  parameter int DIST_WIDTH_DEF  = 32;

  parameter int AXES         = 3;
  parameter int DIR_W        = 16;
  parameter int NRM_W        = 33;
  parameter int T_SHIFT      = 22;
  parameter int CFG_DATA_W   = 64;
  parameter int PADDR_W      = 6;
  parameter int REG_ADDR_LSB = 3;

  typedef enum logic [2:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_VERTEX_C = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic reject;
  } stage_ctl_t;

endpackage

`default_nettype wire

[design/rti_cfg.sv]
// Configuration registers (vertices and normal) behind the APB-style port,
// plus the registered per-edge vectors N x (V2 - V1). Depends on rti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rti_cfg import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready,
  output logic signed [COORD_WIDTH-1:0] vert [AXES][AXES],
  output logic signed [NRM_W-1:0]       nrm [AXES],
  output logic signed [COORD_WIDTH+NRM_W+1:0] edge_m [AXES][AXES]
);

  localparam int VTX_W = 3 * COORD_WIDTH;
  localparam int E_W   = COORD_WIDTH + 1;
  localparam int M_W   = COORD_WIDTH + NRM_W + 2;

  logic [VTX_W-1:0]        vtx_reg [AXES];
  logic signed [NRM_W-1:0] nrm_reg [AXES];
  logic                    wr_en;
  reg_idx_t                reg_idx;
  logic signed [E_W-1:0]   edge_e [AXES][AXES];
  logic signed [M_W-1:0]   m_next [AXES][AXES];

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:REG_ADDR_LSB]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        vtx_reg[i] <= '0;
        nrm_reg[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_VERTEX_A: vtx_reg[0] <= VTX_W'(pwdata);
        REG_VERTEX_B: vtx_reg[1] <= VTX_W'(pwdata);
        REG_VERTEX_C: vtx_reg[2] <= VTX_W'(pwdata);
        REG_NORMAL_X: nrm_reg[0] <= pwdata[NRM_W-1:0];
        REG_NORMAL_Y: nrm_reg[1] <= pwdata[NRM_W-1:0];
        REG_NORMAL_Z: nrm_reg[2] <= pwdata[NRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VERTEX_A: prdata = CFG_DATA_W'(vtx_reg[0]);
      REG_VERTEX_B: prdata = CFG_DATA_W'(vtx_reg[1]);
      REG_VERTEX_C: prdata = CFG_DATA_W'(vtx_reg[2]);
      REG_NORMAL_X: prdata = CFG_DATA_W'(nrm_reg[0]);
      REG_NORMAL_Y: prdata = CFG_DATA_W'(nrm_reg[1]);
      REG_NORMAL_Z: prdata = CFG_DATA_W'(nrm_reg[2]);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    for (int v = 0; v < AXES; v++) begin
      for (int c = 0; c < AXES; c++) begin
        vert[v][c] = vtx_reg[v][c*COORD_WIDTH +: COORD_WIDTH];
      end
    end
    for (int k = 0; k < AXES; k++) begin
      nrm[k] = nrm_reg[k];
    end
  end

  // Edge k runs from vertex k to the next one, wrapping from C back to A.
  // The edge test (e x v) . N equals v . (N x e), so N x e is kept per edge.
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      for (int c = 0; c < AXES; c++) begin
        edge_e[k][c] = E_W'(vert[(k == AXES - 1) ? 0 : k + 1][c]) - E_W'(vert[k][c]);
      end
      m_next[k][0] = M_W'(nrm_reg[1]) * M_W'(edge_e[k][2])
                   - M_W'(nrm_reg[2]) * M_W'(edge_e[k][1]);
      m_next[k][1] = M_W'(nrm_reg[2]) * M_W'(edge_e[k][0])
                   - M_W'(nrm_reg[0]) * M_W'(edge_e[k][2]);
      m_next[k][2] = M_W'(nrm_reg[0]) * M_W'(edge_e[k][1])
                   - M_W'(nrm_reg[1]) * M_W'(edge_e[k][0]);
    end
  end

  always_ff @(posedge clk) begin
    edge_m <= m_next;
  end

endmodule

`default_nettype wire

[design/rti_plane.sv]
// Plane stages: (A - O) . N and D . N, then sign checks and magnitudes for
// the divider. Four register stages. Depends on rti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rti_plane import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] origin [AXES],
  input  logic signed [DIR_W-1:0]       dir [AXES],
  input  logic [DIST_WIDTH-1:0]         best,
  input  logic signed [COORD_WIDTH-1:0] vert [AXES][AXES],
  input  logic signed [NRM_W-1:0]       nrm [AXES],
  output stage_ctl_t                    out_ctl,
  output logic [COORD_WIDTH+NRM_W+2:0]  un,
  output logic [DIR_W+NRM_W+1:0]        ud,
  output logic [3*COORD_WIDTH+3*DIR_W+DIST_WIDTH-1:0] side_out
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PN_W   = DIFF_W + NRM_W;
  localparam int PD_W   = DIR_W + NRM_W;
  localparam int NUM_W  = PN_W + 2;
  localparam int DEN_W  = PD_W + 2;
  localparam int SIDE_W = 3 * COORD_WIDTH + 3 * DIR_W + DIST_WIDTH;

  logic                     v1, v2, v3;
  logic [SIDE_W-1:0]        side0, side1, side2, side3;
  logic signed [DIFF_W-1:0] diff1 [AXES];
  logic signed [DIR_W-1:0]  d1 [AXES];
  logic signed [PN_W-1:0]   pn2 [AXES];
  logic signed [PD_W-1:0]   pd2 [AXES];
  logic signed [NUM_W-1:0]  num3;
  logic signed [DEN_W-1:0]  den3;

  // Side data carried to the end of the pipe: origin, direction, best_t.
  assign side0 = {origin[2], origin[1], origin[0], dir[2], dir[1], dir[0], best};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_ctl <= '0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_ctl.valid  <= v3;
      out_ctl.reject <= (den3 == '0) || (num3 == '0) ||
                        (num3[NUM_W-1] != den3[DEN_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < AXES; c++) begin
        diff1[c] <= DIFF_W'(vert[0][c]) - DIFF_W'(origin[c]);
        d1[c]    <= dir[c];
        pn2[c]   <= PN_W'(diff1[c]) * PN_W'(nrm[c]);
        pd2[c]   <= PD_W'(d1[c]) * PD_W'(nrm[c]);
      end
      num3 <= NUM_W'(pn2[0]) + NUM_W'(pn2[1]) + NUM_W'(pn2[2]);
      den3 <= DEN_W'(pd2[0]) + DEN_W'(pd2[1]) + DEN_W'(pd2[2]);
      un   <= num3[NUM_W-1] ? NUM_W'(-num3) : NUM_W'(num3);
      ud   <= den3[DEN_W-1] ? DEN_W'(-den3) : DEN_W'(den3);
      side1    <= side0;
      side2    <= side1;
      side3    <= side2;
      side_out <= side3;
    end
  end

endmodule

`default_nettype wire

[design/rti_div.sv]
// Restoring divider, one quotient bit per stage: t = |num| * 2^22 / |den|,
// with an overflow test up front and the t range test at the end.
// Depends on rti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rti_div import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  stage_ctl_t                   in_ctl,
  input  logic [COORD_WIDTH+NRM_W+2:0] un,
  input  logic [DIR_W+NRM_W+1:0]       ud,
  input  logic [3*COORD_WIDTH+3*DIR_W+DIST_WIDTH-1:0] side_in,
  output stage_ctl_t                   out_ctl,
  output logic [DIST_WIDTH-1:0]        q,
  output logic [3*COORD_WIDTH+3*DIR_W+DIST_WIDTH-1:0] side_out
);

  localparam int NUM_W  = COORD_WIDTH + NRM_W + 3;
  localparam int DEN_W  = DIR_W + NRM_W + 2;
  localparam int SIDE_W = 3 * COORD_WIDTH + 3 * DIR_W + DIST_WIDTH;
  localparam int K      = DIST_WIDTH - T_SHIFT;
  localparam int HEAD_W = NUM_W - K;
  localparam int CMP_W  = (HEAD_W > DEN_W) ? HEAD_W : DEN_W;
  localparam int DW     = DIST_WIDTH;

  logic [HEAD_W-1:0] head;
  logic              sat;
  stage_ctl_t        ctl_s  [DW+1];
  logic [DW-1:0]     q_s    [DW+1];
  logic [SIDE_W-1:0] side_s [DW+1];
  logic [DEN_W-1:0]  rem_s  [DW];
  logic [DEN_W-1:0]  ud_s   [DW];
  logic [DW-1:0]     low_s  [DW];
  logic [DW-1:0]     best_last;

  // The quotient fits in DIST_WIDTH bits exactly when the dividend's upper
  // part is still below the divisor; that part is also the first remainder.
  assign head = un[NUM_W-1:K];
  assign sat  = CMP_W'(head) >= CMP_W'(ud);
  assign q_s[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else if (adv) begin
      ctl_s[0].valid  <= in_ctl.valid;
      ctl_s[0].reject <= in_ctl.reject || sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0]  <= DEN_W'(head);
      low_s[0]  <= {un[K-1:0], {T_SHIFT{1'b0}}};
      ud_s[0]   <= ud;
      side_s[0] <= side_in;
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_bit
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem_s[i], low_s[i][DW-1]};
    assign ge    = trial >= {1'b0, ud_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[i+1] <= '0;
      end else if (adv) begin
        ctl_s[i+1] <= ctl_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_s[i+1]    <= {q_s[i][DW-2:0], ge};
        side_s[i+1] <= side_s[i];
      end
    end

    if (i < DW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, ud_s[i]}) : trial[DEN_W-1:0];
          low_s[i+1] <= {low_s[i][DW-2:0], 1'b0};
          ud_s[i+1]  <= ud_s[i];
        end
      end
    end
  end

  assign best_last = side_s[DW][DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl.valid  <= ctl_s[DW].valid;
      out_ctl.reject <= ctl_s[DW].reject || (q_s[DW] == '0) || (q_s[DW] >= best_last);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q        <= q_s[DW];
      side_out <= side_s[DW];
    end
  end

endmodule

`default_nettype wire

[design/rti_edge.sv]
// Hit point P = O + round(D * t / 2^22), a sign test on each edge and the
// saturating output register. Depends on rti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rti_edge import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  stage_ctl_t                    in_ctl,
  input  logic [DIST_WIDTH-1:0]         q,
  input  logic [3*COORD_WIDTH+3*DIR_W+DIST_WIDTH-1:0] side_in,
  input  logic signed [COORD_WIDTH-1:0] vert [AXES][AXES],
  input  logic signed [COORD_WIDTH+NRM_W+1:0] edge_m [AXES][AXES],
  output logic                          out_valid,
  output logic                          hit,
  output logic [DIST_WIDTH-1:0]         hit_t,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y,
  output logic signed [COORD_WIDTH-1:0] hit_z
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = DIST_WIDTH;
  localparam int PROD_W = DW + DIR_W + 1;
  localparam int P_W    = ((CW > DW - 5) ? CW : DW - 5) + 1;
  localparam int V_W    = P_W + 1;
  localparam int M_W    = CW + NRM_W + 2;
  localparam int ML_W   = M_W / 2;
  localparam int MH_W   = M_W - ML_W;
  localparam int LP_W   = V_W + ML_W + 1;
  localparam int HP_W   = V_W + MH_W;
  localparam int LS_W   = LP_W + 2;
  localparam int HS_W   = HP_W + 2;
  localparam int TOT_W  = ((HS_W + ML_W > LS_W) ? HS_W + ML_W : LS_W) + 1;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (T_SHIFT - 1);
  localparam logic signed [P_W-1:0] C_MAX = P_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [P_W-1:0] C_MIN = -C_MAX - P_W'(1);

  logic signed [CW-1:0]     o_in [AXES];
  logic signed [DIR_W-1:0]  d_in [AXES];
  logic [DW-1:0]            best_in;

  stage_ctl_t               ctl1, ctl2, ctl3, ctl4, ctl5;
  logic [DW-1:0]            q1, q2, q3, q4, q5;
  logic [DW-1:0]            best1, best2, best3, best4, best5;
  logic signed [CW-1:0]     o1 [AXES];
  logic signed [PROD_W-1:0] prod1 [AXES];
  logic signed [PROD_W-1:0] rsum [AXES];
  logic signed [P_W-1:0]    p2 [AXES];
  logic signed [P_W-1:0]    p3 [AXES];
  logic signed [P_W-1:0]    p4 [AXES];
  logic signed [P_W-1:0]    p5 [AXES];
  logic signed [V_W-1:0]    v3 [AXES][AXES];
  logic signed [LP_W-1:0]   plo4 [AXES][AXES];
  logic signed [HP_W-1:0]   phi4 [AXES][AXES];
  logic signed [LS_W-1:0]   lo5 [AXES];
  logic signed [HS_W-1:0]   hi5 [AXES];
  logic signed [TOT_W-1:0]  tot [AXES];
  logic signed [CW-1:0]     pc [AXES];
  logic                     in_tri;
  logic                     hit_next;

  always_comb begin
    for (int c = 0; c < AXES; c++) begin
      d_in[c] = side_in[DW + c*DIR_W +: DIR_W];
      o_in[c] = side_in[DW + AXES*DIR_W + c*CW +: CW];
      rsum[c] = prod1[c] + RND;
    end
    best_in = side_in[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      ctl1 <= in_ctl;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
      out_valid <= ctl5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1 <= q;
      q2 <= q1;
      q3 <= q2;
      q4 <= q3;
      q5 <= q4;
      best1 <= best_in;
      best2 <= best1;
      best3 <= best2;
      best4 <= best3;
      best5 <= best4;
      for (int c = 0; c < AXES; c++) begin
        o1[c]    <= o_in[c];
        prod1[c] <= PROD_W'(d_in[c]) * PROD_W'($signed({1'b0, q}));
        p2[c]    <= P_W'(o1[c]) + P_W'(rsum[c] >>> T_SHIFT);
        p3[c]    <= p2[c];
        p4[c]    <= p3[c];
        p5[c]    <= p4[c];
      end
      for (int k = 0; k < AXES; k++) begin
        for (int c = 0; c < AXES; c++) begin
          v3[k][c]   <= V_W'(p2[c]) - V_W'(vert[k][c]);
          // The edge vector is split in a low unsigned and a high signed part
          // to keep each multiplier near 32 bits.
          plo4[k][c] <= LP_W'(v3[k][c]) *
                        LP_W'($signed({1'b0, edge_m[k][c][ML_W-1:0]}));
          phi4[k][c] <= HP_W'(v3[k][c]) * HP_W'($signed(edge_m[k][c][M_W-1:ML_W]));
        end
        lo5[k] <= LS_W'(plo4[k][0]) + LS_W'(plo4[k][1]) + LS_W'(plo4[k][2]);
        hi5[k] <= HS_W'(phi4[k][0]) + HS_W'(phi4[k][1]) + HS_W'(phi4[k][2]);
      end
    end
  end

  always_comb begin
    in_tri = 1'b1;
    for (int k = 0; k < AXES; k++) begin
      tot[k] = (TOT_W'(hi5[k]) <<< ML_W) + TOT_W'(lo5[k]);
      in_tri = in_tri && !tot[k][TOT_W-1];
    end
    for (int c = 0; c < AXES; c++) begin
      if (p5[c] > C_MAX) begin
        pc[c] = C_MAX[CW-1:0];
      end else if (p5[c] < C_MIN) begin
        pc[c] = C_MIN[CW-1:0];
      end else begin
        pc[c] = p5[c][CW-1:0];
      end
    end
    hit_next = ctl5.valid && !ctl5.reject && in_tri;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit   <= hit_next;
      hit_t <= hit_next ? q5 : best5;
      hit_x <= hit_next ? pc[0] : '0;
      hit_y <= hit_next ? pc[1] : '0;
      hit_z <= hit_next ? pc[2] : '0;
    end
  end

endmodule

`default_nettype wire

[design/ray_triangle_intersect.sv]
// Ray/triangle intersection, one ray per clock cycle unless the output stalls:
// plane distance by a pipelined restoring divider, then a sign test on each
// edge. The pipe has 4 plane stages, DIST_WIDTH + 2 divider stages with one
// stage per quotient bit and 6 hit-point and edge stages; the whole pipe holds
// while a result is stalled. Triangle and normal are written over the APB-style
// port at byte address 8*i and must only change while no ray is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_triangle_intersect_macros.svh"

module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready,
  input  logic                          ray_valid,
  output logic                          ray_stall,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [DIR_W-1:0]       dir_x,
  input  logic signed [DIR_W-1:0]       dir_y,
  input  logic signed [DIR_W-1:0]       dir_z,
  input  logic [DIST_WIDTH-1:0]         best_t,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output logic                          hit,
  output logic [DIST_WIDTH-1:0]         hit_t,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y,
  output logic signed [COORD_WIDTH-1:0] hit_z
);

  localparam int SIDE_W = 3 * COORD_WIDTH + 3 * DIR_W + DIST_WIDTH;

  logic                                adv;
  logic signed [COORD_WIDTH-1:0]       origin [AXES];
  logic signed [DIR_W-1:0]             dir [AXES];
  logic signed [COORD_WIDTH-1:0]       vert [AXES][AXES];
  logic signed [NRM_W-1:0]             nrm [AXES];
  logic signed [COORD_WIDTH+NRM_W+1:0] edge_m [AXES][AXES];
  stage_ctl_t                          plane_ctl, div_ctl;
  logic [COORD_WIDTH+NRM_W+2:0]        un;
  logic [DIR_W+NRM_W+1:0]              ud;
  logic [SIDE_W-1:0]                   plane_side, div_side;
  logic [DIST_WIDTH-1:0]               div_q;

  // The pipe moves unless a finished item is waiting at the output.
  assign adv       = !(hit_valid && hit_stall);
  assign ray_stall = !adv;

  assign origin[0] = origin_x;
  assign origin[1] = origin_y;
  assign origin[2] = origin_z;
  assign dir[0]    = dir_x;
  assign dir[1]    = dir_y;
  assign dir[2]    = dir_z;

  rti_cfg #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .vert, .nrm, .edge_m
  );

  rti_plane #(.COORD_WIDTH(COORD_WIDTH), .DIST_WIDTH(DIST_WIDTH)) u_plane (
    .clk, .rst, .adv,
    .in_valid (ray_valid && !ray_stall),
    .origin, .dir,
    .best     (best_t),
    .vert, .nrm,
    .out_ctl  (plane_ctl),
    .un, .ud,
    .side_out (plane_side)
  );

  rti_div #(.COORD_WIDTH(COORD_WIDTH), .DIST_WIDTH(DIST_WIDTH)) u_div (
    .clk, .rst, .adv,
    .in_ctl   (plane_ctl),
    .un, .ud,
    .side_in  (plane_side),
    .out_ctl  (div_ctl),
    .q        (div_q),
    .side_out (div_side)
  );

  rti_edge #(.COORD_WIDTH(COORD_WIDTH), .DIST_WIDTH(DIST_WIDTH)) u_edge (
    .clk, .rst, .adv,
    .in_ctl    (div_ctl),
    .q         (div_q),
    .side_in   (div_side),
    .vert, .edge_m,
    .out_valid (hit_valid),
    .hit, .hit_t, .hit_x, .hit_y, .hit_z
  );

  `RTI_ASSERT_IMP(a_miss_zero_point, clk, rst, hit_valid && !hit, (hit_x | hit_y | hit_z) == '0)
  `RTI_ASSERT_IMP(a_hit_t_range, clk, rst, hit_valid && hit, hit_t != '0 && hit_t != '1)
  `RTI_ASSERT_IMP(a_hold_blocks_input, clk, rst, hit_valid && hit_stall, ray_stall)
  `RTI_ASSERT_IMP(a_free_out_moves, clk, rst, !hit_valid, !ray_stall)

endmodule

`default_nettype wire
